>>> sv/asg_pkg.sv
// ----------------------------------------------------------------------------
// asg_pkg: shared types, constants and helpers of the speed governor
// Field widths, Q10 scale factors, mode and urgency codes, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package asg_pkg;

	// field widths
	localparam int unsigned GAP_W   = 16;
	localparam int unsigned SPEED_W = 12;
	localparam int unsigned TIME_W  = 12;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned URG_W   = 2;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDAT_W  = 16;
	localparam int unsigned PROD_W  = 22;

	// speed saturation and parameter defaults
	localparam int unsigned SPEED_SAT              = 2550;
	localparam int unsigned DEF_UPDATE_INTERVAL_MS = 100;
	localparam int unsigned DEF_MAX_SPEED          = 1500;

	// Q10 scale factors
	localparam logic [PROD_W-1:0] Q_070 = PROD_W'(717);
	localparam logic [PROD_W-1:0] Q_090 = PROD_W'(922);
	localparam logic [PROD_W-1:0] Q_110 = PROD_W'(1126);
	localparam logic [PROD_W-1:0] Q_095 = PROD_W'(973);
	localparam logic [PROD_W-1:0] Q_098 = PROD_W'(1004);

	// slow traffic margin and near-speed window, 0.1 km/h
	localparam int unsigned SLOW_MARGIN = 150;
	localparam int unsigned NEAR_WINDOW = 50;

	typedef enum logic [MODE_W-1:0] {
		MODE_FREE   = 3'd0,
		MODE_FOLLOW = 3'd1,
		MODE_SLOW   = 3'd2,
		MODE_CLOSE  = 3'd3,
		MODE_EMERG  = 3'd4
	} mode_t;

	localparam logic [URG_W-1:0] URG_NONE = 2'd0;
	localparam logic [URG_W-1:0] URG_LOW  = 2'd1;
	localparam logic [URG_W-1:0] URG_MID  = 2'd2;
	localparam logic [URG_W-1:0] URG_HIGH = 2'd3;

	typedef enum logic [CIDX_W-1:0] {
		REG_CRITICAL_GAP    = 3'd0,
		REG_CLOSE_GAP       = 3'd1,
		REG_FOLLOW_GAP      = 3'd2,
		REG_FLOOR_SPEED     = 3'd3,
		REG_CRUISE_SPEED    = 3'd4,
		REG_GENTLE_STEP     = 3'd5,
		REG_MODERATE_STEP   = 3'd6,
		REG_AGGRESSIVE_STEP = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [GAP_W-1:0]   critical_gap;
		logic [GAP_W-1:0]   close_gap;
		logic [GAP_W-1:0]   follow_gap;
		logic [SPEED_W-1:0] floor_speed;
		logic [SPEED_W-1:0] cruise_speed;
		logic [SPEED_W-1:0] gentle_step;
		logic [SPEED_W-1:0] moderate_step;
		logic [SPEED_W-1:0] aggressive_step;
	} cfg_t;

	// stage 1 payload: classification plus raw scaled products
	typedef struct packed {
		mode_t              mode;
		logic [URG_W-1:0]   urg;
		logic [SPEED_W-1:0] lead;
		logic [SPEED_W-1:0] own;
		logic [SPEED_W-1:0] flo;
		logic [SPEED_W-1:0] cruise;
		logic [SPEED_W-1:0] step;
		logic               near;
		logic [PROD_W-1:0]  p_own070;
		logic [PROD_W-1:0]  p_lead090;
		logic [PROD_W-1:0]  p_lead110;
		logic [PROD_W-1:0]  p_own095;
		logic [PROD_W-1:0]  p_lead098;
	} s1_t;

	// payload from stage 2 on: target and what the clamp needs
	typedef struct packed {
		mode_t              mode;
		logic [URG_W-1:0]   urg;
		logic [SPEED_W-1:0] own;
		logic [SPEED_W-1:0] flo;
		logic [SPEED_W-1:0] aim;
	} s2_t;

	function automatic logic [SPEED_W-1:0] sat_speed(input logic [SPEED_W-1:0] v);
		return (v > SPEED_W'(SPEED_SAT)) ? SPEED_W'(SPEED_SAT) : v;
	endfunction

	// Q10 product rounded half up
	function automatic logic [SPEED_W-1:0] qround(input logic [PROD_W-1:0] p);
		logic [PROD_W-1:0] s;
		s = p + PROD_W'(512);
		return s[PROD_W-1:10];
	endfunction

	// width of the clamped elapsed time, 0..2*interval
	function automatic int unsigned step_time_w(input int unsigned ivl);
		return $clog2(2 * ivl + 1);
	endfunction

	// width of step * time
	function automatic int unsigned lim_w(input int unsigned ivl);
		return $clog2(SPEED_SAT * 2 * ivl + 1);
	endfunction

endpackage

`default_nettype wire

>>> sv/asg_in_if.sv
// ----------------------------------------------------------------------------
// asg_in_if: sample channel
// One sensor item per handshake: gap, lead and own speed, elapsed time.
// ----------------------------------------------------------------------------
`default_nettype none

interface asg_in_if import asg_pkg::*;;
	logic               valid;
	logic               ready;
	logic [GAP_W-1:0]   gap;
	logic [SPEED_W-1:0] lead_speed;
	logic [SPEED_W-1:0] own_speed;
	logic [TIME_W-1:0]  elapsed_ms;

	modport source (output valid, gap, lead_speed, own_speed, elapsed_ms, input ready);
	modport sink (input valid, gap, lead_speed, own_speed, elapsed_ms, output ready);
endinterface

`default_nettype wire

>>> sv/asg_out_if.sv
// ----------------------------------------------------------------------------
// asg_out_if: result channel
// One result item per sample: new speed, target speed, mode and urgency.
// ----------------------------------------------------------------------------
`default_nettype none

interface asg_out_if import asg_pkg::*;;
	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] new_speed;
	logic [SPEED_W-1:0] aim_speed;
	logic [MODE_W-1:0]  drive_mode;
	logic [URG_W-1:0]   urgency;

	modport source (output valid, new_speed, aim_speed, drive_mode, urgency, input ready);
	modport sink (input valid, new_speed, aim_speed, drive_mode, urgency, output ready);
endinterface

`default_nettype wire

>>> sv/asg_cfg_if.sv
// ----------------------------------------------------------------------------
// asg_cfg_if: register write channel
// Register index and write data, one write per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface asg_cfg_if import asg_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [CDAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/asg_classify.sv
// ----------------------------------------------------------------------------
// asg_classify: pipeline stage 1
// Saturates inputs, picks mode and urgency from the gap and the speeds,
// selects the step, clamps elapsed time, forms the Q10 target products.
// ----------------------------------------------------------------------------
`default_nettype none

module asg_classify import asg_pkg::*; #(
	parameter int unsigned UPDATE_INTERVAL_MS = DEF_UPDATE_INTERVAL_MS
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       load,
	input  wire logic                                       in_valid,
	input  wire logic [GAP_W-1:0]                           gap,
	input  wire logic [SPEED_W-1:0]                         lead_speed,
	input  wire logic [SPEED_W-1:0]                         own_speed,
	input  wire logic [TIME_W-1:0]                          elapsed_ms,
	input  wire cfg_t                                       cfg,
	output logic                                            v_s1,
	output s1_t                                             d_s1,
	output logic [step_time_w(UPDATE_INTERVAL_MS)-1:0]      t_s1
);

	localparam int unsigned TW = step_time_w(UPDATE_INTERVAL_MS);
	localparam logic [TIME_W-1:0] T_MAX = TIME_W'(2 * UPDATE_INTERVAL_MS);

	logic [SPEED_W-1:0] lead, own;
	logic signed [SPEED_W:0] dls;
	logic slow;
	s1_t d;
	logic [TIME_W-1:0] t_clamp;

	// mode, urgency and products
	always_comb begin
		lead = sat_speed(lead_speed);
		own  = sat_speed(own_speed);
		dls  = $signed({1'b0, lead}) - $signed({1'b0, own});
		slow = ({1'b0, lead} + (SPEED_W+1)'(SLOW_MARGIN)) < {1'b0, own};

		d = '0;
		d.lead   = lead;
		d.own    = own;
		d.flo    = sat_speed(cfg.floor_speed);
		d.cruise = sat_speed(cfg.cruise_speed);
		d.near   = (dls < $signed((SPEED_W+1)'(NEAR_WINDOW))) &&
		           (dls > -$signed((SPEED_W+1)'(NEAR_WINDOW)));

		priority if (gap < cfg.critical_gap) begin
			d.mode = MODE_EMERG;
			d.urg  = URG_HIGH;
		end else if (gap < cfg.close_gap) begin
			d.mode = MODE_CLOSE;
			d.urg  = URG_MID;
		end else if (gap < cfg.follow_gap) begin
			d.mode = slow ? MODE_SLOW : MODE_FOLLOW;
			d.urg  = slow ? URG_MID : URG_LOW;
		end else begin
			d.mode = MODE_FREE;
			d.urg  = URG_NONE;
		end

		unique case (d.urg)
			URG_HIGH: d.step = sat_speed(cfg.aggressive_step);
			URG_MID:  d.step = sat_speed(cfg.moderate_step);
			default:  d.step = sat_speed(cfg.gentle_step);
		endcase

		d.p_own070  = PROD_W'(own)  * Q_070;
		d.p_lead090 = PROD_W'(lead) * Q_090;
		d.p_lead110 = PROD_W'(lead) * Q_110;
		d.p_own095  = PROD_W'(own)  * Q_095;
		d.p_lead098 = PROD_W'(lead) * Q_098;

		t_clamp = (elapsed_ms > T_MAX) ? T_MAX : elapsed_ms;
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			d_s1 <= d;
			t_s1 <= TW'(t_clamp);
		end
	end

endmodule

`default_nettype wire

>>> sv/asg_target.sv
// ----------------------------------------------------------------------------
// asg_target: pipeline stage 2
// Rounds the Q10 products, chooses the target speed of the mode and forms
// the unscaled step limit step * time.
// ----------------------------------------------------------------------------
`default_nettype none

module asg_target import asg_pkg::*; #(
	parameter int unsigned UPDATE_INTERVAL_MS = DEF_UPDATE_INTERVAL_MS
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       load,
	input  wire logic                                       v_s1,
	input  wire s1_t                                        d_s1,
	input  wire logic [step_time_w(UPDATE_INTERVAL_MS)-1:0] t_s1,
	output logic                                            v_s2,
	output s2_t                                             d_s2,
	output logic [lim_w(UPDATE_INTERVAL_MS)-1:0]            lim_s2
);

	localparam int unsigned TW = step_time_w(UPDATE_INTERVAL_MS);
	localparam int unsigned LW = lim_w(UPDATE_INTERVAL_MS);
	localparam int unsigned MW = SPEED_W + TW;

	logic [SPEED_W-1:0] r070, r090, r110, r095, r098, slow_aim;
	logic [MW-1:0] lim_full;
	s2_t d;

	// target per mode
	always_comb begin
		r070 = qround(d_s1.p_own070);
		r090 = qround(d_s1.p_lead090);
		r110 = qround(d_s1.p_lead110);
		r095 = qround(d_s1.p_own095);
		r098 = qround(d_s1.p_lead098);
		slow_aim = (r110 < r095) ? r110 : r095;

		d.mode = d_s1.mode;
		d.urg  = d_s1.urg;
		d.own  = d_s1.own;
		d.flo  = d_s1.flo;
		unique case (d_s1.mode)
			MODE_EMERG:  d.aim = (r070 > d_s1.flo) ? r070 : d_s1.flo;
			MODE_CLOSE:  d.aim = (r090 > d_s1.flo) ? r090 : d_s1.flo;
			MODE_SLOW:   d.aim = (slow_aim > d_s1.flo) ? slow_aim : d_s1.flo;
			MODE_FOLLOW: d.aim = d_s1.near ? d_s1.own : r098;
			default:     d.aim = d_s1.cruise;
		endcase

		lim_full = MW'(d_s1.step) * MW'(t_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (load) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && v_s1) begin
			d_s2   <= d;
			lim_s2 <= LW'(lim_full);
		end
	end

endmodule

`default_nettype wire

>>> sv/asg_limit.sv
// ----------------------------------------------------------------------------
// asg_limit: pipeline stages 3 to 6
// Rate limiter. Compares |aim - own| * den with step * time, divides the
// rounded limit by den through a reciprocal product with one correction,
// moves own speed by that change and clamps to floor and maximum.
// den is the update interval, doubled at urgency zero.
// ----------------------------------------------------------------------------
`default_nettype none

module asg_limit import asg_pkg::*; #(
	parameter int unsigned UPDATE_INTERVAL_MS = DEF_UPDATE_INTERVAL_MS,
	parameter int unsigned MAX_SPEED          = DEF_MAX_SPEED
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [3:0]                          load,
	input  wire logic                                v_s2,
	input  wire s2_t                                 d_s2,
	input  wire logic [lim_w(UPDATE_INTERVAL_MS)-1:0] lim_s2,
	output logic [3:0]                               vld,
	output s2_t                                      d_s6,
	output logic [SPEED_W-1:0]                       speed_s6
);

	localparam int unsigned IVL        = UPDATE_INTERVAL_MS;
	localparam int unsigned DEN_WIDE   = 2 * IVL;
	localparam int unsigned DW         = $clog2(DEN_WIDE + 1);
	localparam int unsigned LW         = lim_w(IVL);
	localparam int unsigned LIM_MAX    = SPEED_SAT * DEN_WIDE;
	localparam int unsigned XW         = $clog2(LIM_MAX + IVL + 1);
	localparam int unsigned SH         = XW;
	localparam int unsigned RW         = SH + 1;
	localparam int unsigned PW         = XW + RW;
	localparam int unsigned AW         = SPEED_W + DW;
	localparam int unsigned QW         = XW + DW;
	localparam int unsigned NW         = SPEED_W + 2;
	localparam longint unsigned ONE_SH = 64'd1 << SH;

	localparam logic [DW-1:0] DEN_W_C   = DW'(DEN_WIDE);
	localparam logic [DW-1:0] DEN_N_C   = DW'(IVL);
	localparam logic [XW-1:0] HALF_W_C  = XW'(IVL);
	localparam logic [XW-1:0] HALF_N_C  = XW'(IVL / 2);
	localparam logic [PW-1:0] RCP_W_C   = PW'(ONE_SH / DEN_WIDE);
	localparam logic [PW-1:0] RCP_N_C   = PW'(ONE_SH / IVL);
	localparam logic [SPEED_W-1:0] MAX_C = SPEED_W'(MAX_SPEED);

	// stage 3 registers
	s2_t                d_s3;
	logic [LW-1:0]      lim_s3;
	logic [XW-1:0]      x_s3;
	logic [SPEED_W-1:0] adiff_s3;
	logic               up_s3, wide_s3;
	// stage 4 registers
	s2_t                d_s4;
	logic [LW-1:0]      lim_s4, adx_s4;
	logic [XW-1:0]      x_s4, q0_s4;
	logic               up_s4, wide_s4;
	// stage 5 registers
	s2_t                d_s5;
	logic [XW-1:0]      x_s5, q0_s5, qd_s5;
	logic               up_s5, wide_s5, take_s5;

	logic signed [SPEED_W:0] diff;
	logic [XW-1:0] x_c;
	logic [PW-1:0] prod_q;
	logic [AW-1:0] adx_full;
	logic [QW-1:0] qd_full;
	logic [DW-1:0] den4, den5, den6;
	logic [XW-1:0] rem, q;
	logic [NW-1:0] chg;
	logic signed [NW-1:0] nsp, flo_s, max_s;
	logic [SPEED_W-1:0] speed_c;

	// stage 3: signed distance to target, rounded limit numerator
	always_comb begin
		diff = $signed({1'b0, d_s2.aim}) - $signed({1'b0, d_s2.own});
		x_c  = XW'(lim_s2) + ((d_s2.urg == URG_NONE) ? HALF_W_C : HALF_N_C);
	end

	// stage 4: reciprocal product and scaled distance
	always_comb begin
		den4     = wide_s3 ? DEN_W_C : DEN_N_C;
		prod_q   = PW'(x_s3) * (wide_s3 ? RCP_W_C : RCP_N_C);
		adx_full = AW'(adiff_s3) * AW'(den4);
	end

	// stage 5: back-multiply the quotient estimate
	always_comb begin
		den5    = wide_s4 ? DEN_W_C : DEN_N_C;
		qd_full = QW'(q0_s4) * QW'(den5);
	end

	// stage 6: quotient correction, step and clamp
	always_comb begin
		den6  = wide_s5 ? DEN_W_C : DEN_N_C;
		rem   = x_s5 - qd_s5;
		q     = (rem >= XW'(den6)) ? (q0_s5 + XW'(1)) : q0_s5;
		chg   = NW'(q);
		flo_s = $signed(NW'(d_s5.flo));
		max_s = $signed(NW'(MAX_C));
		if (take_s5) begin
			nsp = $signed(NW'(d_s5.aim));
		end else if (up_s5) begin
			nsp = $signed(NW'(d_s5.own) + chg);
		end else begin
			nsp = $signed(NW'(d_s5.own) - chg);
		end
		if (nsp < flo_s) begin
			nsp = flo_s;
		end
		if (nsp > max_s) begin
			nsp = max_s;
		end
		if (nsp < 0) begin
			nsp = '0;
		end
		speed_c = SPEED_W'(nsp);
	end

	// valid bits of stages 3..6
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (load[0]) vld[0] <= v_s2;
			if (load[1]) vld[1] <= vld[0];
			if (load[2]) vld[2] <= vld[1];
			if (load[3]) vld[3] <= vld[2];
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (load[0] && v_s2) begin
			d_s3     <= d_s2;
			lim_s3   <= lim_s2;
			x_s3     <= x_c;
			adiff_s3 <= SPEED_W'(diff < 0 ? -diff : diff);
			up_s3    <= (diff > 0);
			wide_s3  <= (d_s2.urg == URG_NONE);
		end
		if (load[1] && vld[0]) begin
			d_s4    <= d_s3;
			lim_s4  <= lim_s3;
			adx_s4  <= LW'(adx_full);
			x_s4    <= x_s3;
			q0_s4   <= prod_q[SH +: XW];
			up_s4   <= up_s3;
			wide_s4 <= wide_s3;
		end
		if (load[2] && vld[1]) begin
			d_s5    <= d_s4;
			x_s5    <= x_s4;
			q0_s5   <= q0_s4;
			qd_s5   <= XW'(qd_full);
			up_s5   <= up_s4;
			wide_s5 <= wide_s4;
			take_s5 <= (adx_s4 <= lim_s4);
		end
		if (load[3] && vld[2]) begin
			d_s6     <= d_s5;
			speed_s6 <= speed_c;
		end
	end

endmodule

`default_nettype wire

>>> sv/acc_speed_governor.sv
// ----------------------------------------------------------------------------
// acc_speed_governor: rate-limited adaptive cruise speed governor
// Six-stage pipeline from a sensor item to a new ego speed command.
// ----------------------------------------------------------------------------
// Usage:
//   sample: valid/ready channel, one item per handshake (gap, lead_speed,
//           own_speed, elapsed_ms). result: one item per sample, in order
//           (new_speed, aim_speed, drive_mode, urgency). cfg: register
//           writes by index, always ready, applied on the next cycle; write
//           only while no item is in flight.
//   Stages: an accepted item reaches result.valid through one register per
//   stage: classify, target, distance, reciprocal product, back-multiply
//   and correct/clamp. Throughput: one item per cycle while result.ready
//   holds; every stage holds one item and a stage moves on whenever the
//   one after it is empty or moving, so bubbles close.
//   Receiver stall: the last stage holds its result, earlier stages keep
//   filling, and sample.ready drops only once all six stages are full.
//   Reset: all stages empty, the cfg registers take their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_speed_governor import asg_pkg::*; #(
	parameter int unsigned UPDATE_INTERVAL_MS = DEF_UPDATE_INTERVAL_MS,
	parameter int unsigned MAX_SPEED          = DEF_MAX_SPEED
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	asg_in_if.sink     sample,
	asg_out_if.source  result,
	asg_cfg_if.sink    cfg
);

	localparam int unsigned TW = step_time_w(UPDATE_INTERVAL_MS);
	localparam int unsigned LW = lim_w(UPDATE_INTERVAL_MS);

	cfg_t cfg_q;
	logic [5:0] vld, rdy;
	logic [3:0] vld_tail;
	s1_t d_s1;
	s2_t d_s2, d_s6;
	logic [TW-1:0] t_s1;
	logic [LW-1:0] lim_s2;
	logic [SPEED_W-1:0] speed_s6;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.critical_gap    <= GAP_W'(500);
			cfg_q.close_gap       <= GAP_W'(1500);
			cfg_q.follow_gap      <= GAP_W'(3000);
			cfg_q.floor_speed     <= SPEED_W'(0);
			cfg_q.cruise_speed    <= SPEED_W'(900);
			cfg_q.gentle_step     <= SPEED_W'(10);
			cfg_q.moderate_step   <= SPEED_W'(30);
			cfg_q.aggressive_step <= SPEED_W'(80);
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_CRITICAL_GAP:    cfg_q.critical_gap    <= cfg.data;
				REG_CLOSE_GAP:       cfg_q.close_gap       <= cfg.data;
				REG_FOLLOW_GAP:      cfg_q.follow_gap      <= cfg.data;
				REG_FLOOR_SPEED:     cfg_q.floor_speed     <= cfg.data[SPEED_W-1:0];
				REG_CRUISE_SPEED:    cfg_q.cruise_speed    <= cfg.data[SPEED_W-1:0];
				REG_GENTLE_STEP:     cfg_q.gentle_step     <= cfg.data[SPEED_W-1:0];
				REG_MODERATE_STEP:   cfg_q.moderate_step   <= cfg.data[SPEED_W-1:0];
				REG_AGGRESSIVE_STEP: cfg_q.aggressive_step <= cfg.data[SPEED_W-1:0];
			endcase
		end
	end

	// per-stage ready chain: a stage loads when it is empty or drains
	always_comb begin
		rdy[5] = !vld[5] || result.ready;
		for (int k = 4; k >= 0; k--) begin
			rdy[k] = !vld[k] || rdy[k+1];
		end
	end

	assign sample.ready = rdy[0];
	assign vld[5:2]     = vld_tail;

	asg_classify #(
		.UPDATE_INTERVAL_MS (UPDATE_INTERVAL_MS)
	) u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (rdy[0]),
		.in_valid   (sample.valid),
		.gap        (sample.gap),
		.lead_speed (sample.lead_speed),
		.own_speed  (sample.own_speed),
		.elapsed_ms (sample.elapsed_ms),
		.cfg        (cfg_q),
		.v_s1       (vld[0]),
		.d_s1       (d_s1),
		.t_s1       (t_s1)
	);

	asg_target #(
		.UPDATE_INTERVAL_MS (UPDATE_INTERVAL_MS)
	) u_target (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (rdy[1]),
		.v_s1   (vld[0]),
		.d_s1   (d_s1),
		.t_s1   (t_s1),
		.v_s2   (vld[1]),
		.d_s2   (d_s2),
		.lim_s2 (lim_s2)
	);

	asg_limit #(
		.UPDATE_INTERVAL_MS (UPDATE_INTERVAL_MS),
		.MAX_SPEED          (MAX_SPEED)
	) u_limit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (rdy[5:2]),
		.v_s2     (vld[1]),
		.d_s2     (d_s2),
		.lim_s2   (lim_s2),
		.vld      (vld_tail),
		.d_s6     (d_s6),
		.speed_s6 (speed_s6)
	);

	// result item
	assign result.valid      = vld[5];
	assign result.new_speed  = speed_s6;
	assign result.aim_speed  = d_s6.aim;
	assign result.drive_mode = MODE_W'(d_s6.mode);
	assign result.urgency    = d_s6.urg;

	// an accepted sample occupies stage 1 on the next cycle
	a_sample_enters: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> vld[0])
		else $error("accepted sample did not enter stage 1");

	// the clamp keeps the command at or below the maximum speed
	a_max_speed: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.new_speed <= SPEED_W'(MAX_SPEED))
		else $error("new_speed above maximum");

	// emergency and only emergency carries the highest urgency
	a_emerg_urg: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.drive_mode == MODE_EMERG) == (result.urgency == URG_HIGH)))
		else $error("emergency mode and urgency disagree");

	// free drive and only free drive carries no urgency
	a_free_urg: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.drive_mode == MODE_FREE) == (result.urgency == URG_NONE)))
		else $error("free mode and urgency disagree");

endmodule

`default_nettype wire
